// ===== rtl/core/pn_pkg.sv =====
// Shared types, codes and constants of the path normalizer.
package pn_pkg;

   // Default sizing, handed to the top level parameters
   localparam int DEF_PATH_BYTES   = 1024;
   localparam int DEF_MAX_SEGMENTS = 64;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int CAP_W   = 11;
   localparam int LEN_W   = 10;
   localparam int MAX_LEN = (2 ** LEN_W) - 1;

   // Result tdata: status, out_length, out_byte, zero fill to whole bytes
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - 1 - LEN_W - BYTE_W;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // Command codes on req_tuser
   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

   // Characters
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

   // Phase of the current path
   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_DRAIN,
      PH_DONE
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESTORE,
      ST_RESTORE_END,
      ST_STATUS,
      ST_READ
   } ctrl_state_type;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_BYTE,
      OP_CLOSE,
      OP_RESTORE,
      OP_STATUS,
      OP_FETCH,
      OP_SEND
   } dp_op_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      phase_type phase;
      logic      pop_on_slash;
      logic      pop_on_end;
      logic      out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/path_normalizer.sv =====
// Path normalizer: removes dot segments from a byte-serial path and drains the result.
// Path byte: the next transaction is taken at the following edge; a slash that closes
// ".." over a kept segment also passes ST_RESTORE (registered read of the segment-start stack).
// End marker and drain tick: input is held while ST_STATUS or ST_READ waits for a free result
// register (low rsp_tready stalls), also in ST_RESTORE_END if a final ".." pops a kept segment.
// Synchronous reset clears control state and sets capacity to 1024; stores need no clearing.
module path_normalizer import pn_pkg::*; #(
   parameter int PATH_BYTES   = DEF_PATH_BYTES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] path_byte
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] status, [10:1] out_length, [18:11] out_byte
   output logic                  rsp_tuser,   // [0] is_status
   output logic                  rsp_tlast,   // out_last
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data  // out_capacity
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer
   pn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // Stores, counters and result register
   pn_datapath #(
      .PATH_BYTES   (PATH_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .path_byte   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/core/pn_ctrl.sv =====
// Controller state machine of the path normalizer: sequences each transaction.
module pn_ctrl import pn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  dp_status_type        dp_status,
   output dp_cmd_type           dp_cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_cmd)
                  CMD_BYTE: begin
                     if (dp_status.pop_on_slash) state_in = ST_RESTORE;
                  end
                  CMD_END: begin
                     if (dp_status.phase == PH_COLLECT) begin
                        state_in = dp_status.pop_on_end ? ST_RESTORE_END : ST_STATUS;
                     end
                  end
                  CMD_DRAIN: begin
                     if (dp_status.phase == PH_DRAIN) state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESTORE:     state_in = ST_IDLE;
         ST_RESTORE_END: state_in = ST_STATUS;
         ST_STATUS: begin
            if (dp_status.out_free) state_in = ST_IDLE;
         end
         ST_READ: begin
            if (dp_status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      dp_cmd.op  = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_cmd)
                  CMD_BYTE: dp_cmd.op = OP_BYTE;
                  CMD_END: begin
                     if (dp_status.phase == PH_COLLECT) dp_cmd.op = OP_CLOSE;
                  end
                  CMD_DRAIN: begin
                     if (dp_status.phase == PH_DRAIN) dp_cmd.op = OP_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESTORE:     dp_cmd.op = OP_RESTORE;
         ST_RESTORE_END: dp_cmd.op = OP_RESTORE;
         ST_STATUS: begin
            if (dp_status.out_free) dp_cmd.op = OP_STATUS;
         end
         ST_READ: begin
            if (dp_status.out_free) dp_cmd.op = OP_SEND;
         end
         default: ;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/pn_datapath.sv =====
// Datapath of the path normalizer: path store, segment stack, counters, result register.
module pn_datapath import pn_pkg::*; #(
   parameter int PATH_BYTES   = DEF_PATH_BYTES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [BYTE_W-1:0]     path_byte,
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int AW    = $clog2(PATH_BYTES);
   localparam int CW    = $clog2(PATH_BYTES + 1);
   localparam int DW    = $clog2(MAX_SEGMENTS + 1);
   localparam int SW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CMP_W = (CW + 1 > CAP_W) ? CW + 1 : CAP_W;

   // Path state
   phase_type         phase_ff, phase_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [CW-1:0]     write_pos_ff, write_pos_in;
   logic [CW-1:0]     input_count_ff, input_count_in;
   logic [CW-1:0]     token_len_ff, token_len_in;
   logic [1:0]        token_dots_ff, token_dots_in;
   logic              absolute_ff, absolute_in;
   logic              error_ff, error_in;
   logic [LEN_W-1:0]  read_pos_ff, read_pos_in;
   logic [LEN_W-1:0]  result_len_ff, result_len_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;

   // Memories
   logic [BYTE_W-1:0] store_mem [PATH_BYTES];
   logic [BYTE_W-1:0] store_rd_ff;
   logic              store_we, store_re;
   logic [AW-1:0]     store_waddr, store_raddr;
   logic [BYTE_W-1:0] store_wdata;
   logic [AW-1:0]     seg_mem [MAX_SEGMENTS];
   logic [AW-1:0]     seg_rd_ff;
   logic              seg_we, seg_re;
   logic [SW-1:0]     seg_waddr, seg_raddr;
   logic [AW-1:0]     seg_wdata;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic              out_load;
   logic              out_is_status_ff, out_is_status_in;
   logic              out_status_ff, out_status_in;
   logic [LEN_W-1:0]  out_length_ff, out_length_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   // Current values; a byte after the end starts a fresh path
   logic              restart;
   logic [DW-1:0]     cur_depth;
   logic [CW-1:0]     cur_wp, cur_count, cur_tok_len;
   logic [1:0]        cur_dots;
   logic              cur_abs, cur_err;

   // Token close
   logic              close_live, is_dotseg, is_dotdot, at_top, seg_full, pop_close;
   logic [CW-1:0]     tok_start;
   logic [CW-1:0]     close_wp;
   logic [DW-1:0]     close_depth;
   logic              close_err, close_keep;

   // Byte intake
   logic              byte_live, is_slash, is_dot, too_long, sep_skip;
   logic [CW-1:0]     count_next, data_addr;
   logic [1:0]        dots_next;

   // Status and drain
   logic [CMP_W-1:0]  path_len;
   logic              fail;
   logic [LEN_W:0]    read_next;
   logic              read_last;
   logic [BYTE_W-1:0] drain_char;

   // Current path values
   always_comb begin
      restart     = phase_ff != PH_COLLECT;
      cur_depth   = restart ? '0 : depth_ff;
      cur_wp      = restart ? '0 : write_pos_ff;
      cur_count   = restart ? '0 : input_count_ff;
      cur_tok_len = restart ? '0 : token_len_ff;
      cur_dots    = restart ? '0 : token_dots_ff;
      cur_abs     = restart ? 1'b0 : absolute_ff;
      cur_err     = restart ? 1'b0 : error_ff;
   end

   // Token close: drop dot segments, pop on ".." below top, push otherwise unless full
   always_comb begin
      at_top      = cur_depth == '0;
      close_live  = (cur_tok_len != '0) && !cur_err;
      tok_start   = cur_wp - cur_tok_len - CW'(!at_top);
      is_dotseg   = (cur_tok_len <= CW'(2)) && (cur_tok_len == CW'(cur_dots));
      is_dotdot   = is_dotseg && (cur_tok_len == CW'(2));
      seg_full    = cur_depth >= DW'(MAX_SEGMENTS);
      pop_close   = close_live && is_dotdot && !at_top;
      close_wp    = cur_wp;
      close_depth = cur_depth;
      close_err   = cur_err;
      close_keep  = 1'b0;
      if (close_live) begin
         if (is_dotseg) begin
            close_wp = tok_start;
            if (is_dotdot) begin
               if (at_top) begin
                  if (cur_abs) close_err = 1'b1;
               end else begin
                  close_depth = cur_depth - 1'b1;
               end
            end
         end else if (seg_full) begin
            close_err = 1'b1;
         end else begin
            close_keep  = 1'b1;
            close_depth = cur_depth + 1'b1;
         end
      end
   end

   // Byte intake; a new token after a kept segment skips its separator slot
   always_comb begin
      byte_live  = (path_byte != CHAR_NUL) && !cur_err;
      is_slash   = path_byte == CHAR_SLASH;
      is_dot     = path_byte == CHAR_DOT;
      count_next = cur_count + 1'b1;
      too_long   = count_next >= CW'(PATH_BYTES);
      sep_skip   = (cur_tok_len == '0) && !at_top;
      data_addr  = cur_wp + CW'(sep_skip);
      dots_next  = (is_dot && cur_dots != 2'd3) ? cur_dots + 1'b1 : 2'd3;
   end

   // Status figures and drain character
   always_comb begin
      path_len = CMP_W'(write_pos_ff) + CMP_W'(absolute_ff);
      if (path_len == '0) path_len = CMP_W'(1);
      fail = error_ff || (path_len > CMP_W'(MAX_LEN)) || (path_len >= CMP_W'(capacity_ff));
      read_next = {1'b0, read_pos_ff} + 1'b1;
      read_last = read_next >= {1'b0, result_len_ff};
      if (write_pos_ff == '0) begin
         drain_char = absolute_ff ? CHAR_SLASH : CHAR_DOT;
      end else if (absolute_ff && read_pos_ff == '0) begin
         drain_char = CHAR_SLASH;
      end else begin
         drain_char = store_rd_ff;
      end
   end

   // Operation decode
   always_comb begin
      phase_in         = phase_ff;
      depth_in         = depth_ff;
      write_pos_in     = write_pos_ff;
      input_count_in   = input_count_ff;
      token_len_in     = token_len_ff;
      token_dots_in    = token_dots_ff;
      absolute_in      = absolute_ff;
      error_in         = error_ff;
      read_pos_in      = read_pos_ff;
      result_len_in    = result_len_ff;
      store_we         = 1'b0;
      store_waddr      = AW'(cur_wp);
      store_wdata      = CHAR_SLASH;
      store_re         = 1'b0;
      store_raddr      = absolute_ff ? AW'(read_pos_ff - 1'b1) : AW'(read_pos_ff);
      seg_we           = 1'b0;
      seg_waddr        = SW'(cur_depth);
      seg_wdata        = AW'(tok_start);
      seg_re           = 1'b0;
      seg_raddr        = SW'(cur_depth - 1'b1);
      out_load         = 1'b0;
      out_is_status_in = 1'b0;
      out_status_in    = 1'b0;
      out_length_in    = '0;
      out_byte_in      = '0;
      out_last_in      = 1'b0;
      unique case (cmd.op)
         OP_BYTE: begin
            phase_in       = PH_COLLECT;
            read_pos_in    = '0;
            depth_in       = cur_depth;
            write_pos_in   = cur_wp;
            input_count_in = cur_count;
            token_len_in   = cur_tok_len;
            token_dots_in  = cur_dots;
            absolute_in    = cur_abs;
            error_in       = cur_err;
            seg_re         = 1'b1;
            if (byte_live) begin
               if (cur_count == '0 && is_slash) absolute_in = 1'b1;
               input_count_in = count_next;
               if (too_long) begin
                  error_in = 1'b1;
               end else if (is_slash) begin
                  write_pos_in = close_wp;
                  depth_in     = close_depth;
                  error_in     = close_err;
                  seg_we       = close_keep;
                  store_we     = close_keep;
                  if (close_live) begin
                     token_len_in  = '0;
                     token_dots_in = '0;
                  end
               end else begin
                  store_we      = 1'b1;
                  store_waddr   = AW'(data_addr);
                  store_wdata   = path_byte;
                  write_pos_in  = data_addr + 1'b1;
                  token_len_in  = cur_tok_len + 1'b1;
                  token_dots_in = dots_next;
               end
            end
         end
         OP_CLOSE: begin
            seg_re       = 1'b1;
            write_pos_in = close_wp;
            depth_in     = close_depth;
            error_in     = close_err;
            seg_we       = close_keep;
            store_we     = close_keep;
            if (close_live) begin
               token_len_in  = '0;
               token_dots_in = '0;
            end
         end
         OP_RESTORE: begin
            write_pos_in = CW'(seg_rd_ff);
         end
         OP_STATUS: begin
            out_load         = 1'b1;
            out_is_status_in = 1'b1;
            out_status_in    = fail;
            out_length_in    = fail ? '0 : LEN_W'(path_len);
            out_last_in      = fail;
            error_in         = fail;
            result_len_in    = fail ? '0 : LEN_W'(path_len);
            read_pos_in      = '0;
            phase_in         = fail ? PH_DONE : PH_DRAIN;
         end
         OP_FETCH: begin
            store_re = 1'b1;
         end
         OP_SEND: begin
            out_load    = 1'b1;
            out_byte_in = drain_char;
            out_last_in = read_last;
            read_pos_in = LEN_W'(read_next);
            if (read_last) phase_in = PH_DONE;
         end
         default: ;
      endcase
   end

   // Capacity register and result valid
   always_comb begin
      capacity_in  = csr_wr_en ? csr_wr_data : capacity_ff;
      out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COLLECT;
         depth_ff       <= '0;
         write_pos_ff   <= '0;
         input_count_ff <= '0;
         token_len_ff   <= '0;
         token_dots_ff  <= '0;
         absolute_ff    <= 1'b0;
         error_ff       <= 1'b0;
         read_pos_ff    <= '0;
         result_len_ff  <= '0;
         capacity_ff    <= CAP_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         depth_ff       <= depth_in;
         write_pos_ff   <= write_pos_in;
         input_count_ff <= input_count_in;
         token_len_ff   <= token_len_in;
         token_dots_ff  <= token_dots_in;
         absolute_ff    <= absolute_in;
         error_ff       <= error_in;
         read_pos_ff    <= read_pos_in;
         result_len_ff  <= result_len_in;
         capacity_ff    <= capacity_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_is_status_ff <= out_is_status_in;
         out_status_ff    <= out_status_in;
         out_length_ff    <= out_length_in;
         out_byte_ff      <= out_byte_in;
         out_last_ff      <= out_last_in;
      end
   end

   // Path store, registered read
   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= store_wdata;
      if (store_re) store_rd_ff <= store_mem[store_raddr];
   end

   // Segment start stack, registered read
   always_ff @(posedge clock) begin
      if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
      if (seg_re) seg_rd_ff <= seg_mem[seg_raddr];
   end

   // Status to controller and result ports
   always_comb begin
      status.phase        = phase_ff;
      status.pop_on_slash = byte_live && !too_long && is_slash && pop_close;
      status.pop_on_end   = pop_close;
      status.out_free     = !out_valid_ff || rsp_tready;
      rsp_tvalid          = out_valid_ff;
      rsp_tuser           = out_is_status_ff;
      rsp_tlast           = out_last_ff;
      rsp_tdata           = {{RSP_PAD_W{1'b0}}, out_byte_ff, out_length_ff, out_status_ff};
   end

   // Results are only loaded when the result register can take them
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STATUS || cmd.op == OP_SEND) |-> (!out_valid_ff || rsp_tready))
      else $error("result loaded over a pending transaction");

   // A pointer restore always follows a token close that popped
   a_restore_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESTORE) |-> ($past(cmd.op) == OP_BYTE || $past(cmd.op) == OP_CLOSE))
      else $error("restore without a preceding close");

   // Draining only follows a successful status
   a_drain_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN) |-> !error_ff)
      else $error("draining a failed path");

   // Store pointer and stack depth stay in range
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (write_pos_ff < CW'(PATH_BYTES)) && (depth_ff <= DW'(MAX_SEGMENTS)))
      else $error("write pointer or depth out of range");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for path_normalizer: directed table, limit paths and random paths.
`timescale 1ns / 100ps

module tb_top;
   import pn_pkg::*;

   localparam int PATH_BYTES   = DEF_PATH_BYTES;
   localparam int MAX_SEGMENTS = DEF_MAX_SEGMENTS;
   localparam int HOLD_CYCLES  = 300;

   // cmd 3 has no meaning for the block and must be ignored
   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;

   // Where a directed row takes its expected response from
   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_NONE,
      EXP_TYPED
   } exp_src_type;

   typedef struct packed {
      logic              is_status;
      logic              status;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data;
      logic              last_flag;
   } rsp_item_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] b;
      exp_src_type       src;
      rsp_item_type      rsp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // [7:0] path_byte
   logic [CMD_W-1:0]      req_tuser;   // [1:0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] status, [10:1] out_length, [18:11] out_byte
   logic                  rsp_tuser;   // [0] is_status
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CAP_W-1:0]      csr_wr_data;

   path_normalizer #(
      .PATH_BYTES   (PATH_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Shared control between the request side, the response side and the checker
   rsp_item_type expected_rsp[$];
   int           errors = 0;
   int           sent = 0;
   bit           gaps_on = 1'b1;
   bit           long_hold = 1'b0;

   // ---------------------------------------------------------------------------
   // Normalizer shadow state
   // ---------------------------------------------------------------------------
   logic [CAP_W-1:0]  cap_model;
   logic [BYTE_W-1:0] path_mem [PATH_BYTES];
   int unsigned       seg_mem [MAX_SEGMENTS];
   int unsigned       depth_cnt, wr_pos, in_cnt, tok_len, tok_dots, rd_pos, result_len;
   bit                abs_path, failed;
   phase_type         cur_phase;

   function automatic void restart_path();
      depth_cnt  = 0;
      wr_pos     = 0;
      in_cnt     = 0;
      tok_len    = 0;
      tok_dots   = 0;
      abs_path   = 1'b0;
      failed     = 1'b0;
      cur_phase  = PH_COLLECT;
      rd_pos     = 0;
      result_len = 0;
   endfunction

   // Finish the token that a slash or the end marker closes
   function automatic void close_segment();
      int unsigned sep, start;
      if (tok_len == 0 || failed) return;
      sep   = (depth_cnt > 0) ? 1 : 0;
      start = wr_pos - tok_len - sep;
      if (tok_len <= 2 && tok_dots == tok_len) begin
         // "." or "..": drop the token itself
         wr_pos = start;
         if (tok_len == 2) begin
            if (depth_cnt == 0) begin
               if (abs_path) failed = 1'b1;
            end else begin
               depth_cnt--;
               wr_pos = seg_mem[depth_cnt % MAX_SEGMENTS];
            end
         end
      end else if (depth_cnt >= MAX_SEGMENTS) begin
         failed = 1'b1;
      end else begin
         seg_mem[depth_cnt] = start;
         depth_cnt++;
      end
      tok_len  = 0;
      tok_dots = 0;
   endfunction

   function automatic void put_byte(input logic [BYTE_W-1:0] b);
      path_mem[wr_pos % PATH_BYTES] = b;
      wr_pos++;
   endfunction

   function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
      if (b == CHAR_NUL || failed) return;
      if (in_cnt == 0 && b == CHAR_SLASH) abs_path = 1'b1;
      in_cnt++;
      if (in_cnt >= PATH_BYTES) begin
         failed = 1'b1;
         return;
      end
      if (b == CHAR_SLASH) begin
         close_segment();
         return;
      end
      if (tok_len == 0 && depth_cnt > 0) put_byte(CHAR_SLASH);
      put_byte(b);
      tok_len++;
      if (b == CHAR_DOT) begin
         if (tok_dots < 3) tok_dots++;
      end else begin
         tok_dots = 3;
      end
   endfunction

   // Advance the shadow state by one transaction; returns 1 when a response follows
   function automatic bit predict_rsp(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                                      output rsp_item_type r);
      int unsigned       len;
      logic [BYTE_W-1:0] ch;
      r = '0;
      case (cmd)
         CMD_BYTE: begin
            if (cur_phase != PH_COLLECT) restart_path();
            absorb_byte(b);
            return 1'b0;
         end
         CMD_END: begin
            if (cur_phase != PH_COLLECT) return 1'b0;
            close_segment();
            len = wr_pos + abs_path;
            if (len == 0) len = 1;
            if (len > MAX_LEN || len >= cap_model) failed = 1'b1;
            r.is_status = 1'b1;
            r.status    = failed;
            r.length    = failed ? '0 : LEN_W'(len);
            r.last_flag = failed;
            result_len  = failed ? 0 : len;
            rd_pos      = 0;
            cur_phase   = failed ? PH_DONE : PH_DRAIN;
            return 1'b1;
         end
         CMD_DRAIN: begin
            if (cur_phase != PH_DRAIN) return 1'b0;
            if (wr_pos == 0)
               ch = abs_path ? CHAR_SLASH : CHAR_DOT;
            else if (abs_path)
               ch = (rd_pos == 0) ? CHAR_SLASH : path_mem[(rd_pos - 1) % PATH_BYTES];
            else
               ch = path_mem[rd_pos % PATH_BYTES];
            r.data      = ch;
            r.last_flag = (rd_pos + 1 >= result_len);
            rd_pos++;
            if (rd_pos >= result_len) cur_phase = PH_DONE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: random back-pressure plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : rsp_side
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = gaps_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, got tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("is_status", want.is_status, rsp_tuser);
            check_field("status", want.status, rsp_tdata[0]);
            check_field("out_length", want.length, rsp_tdata[LEN_W:1]);
            check_field("out_byte", want.data, rsp_tdata[LEN_W+BYTE_W:LEN_W+1]);
            check_field("out_last", want.last_flag, rsp_tlast);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side helpers (all entered and left at a falling edge)
   // ---------------------------------------------------------------------------
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                           input exp_src_type src = EXP_MODEL,
                           input rsp_item_type typed = '0);
      int           gap;
      bit           got;
      rsp_item_type pred;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = b;
      do @(posedge clock); while (req_tready !== 1'b1);
      got = predict_rsp(cmd, b, pred);
      case (src)
         EXP_MODEL: if (got) expected_rsp.push_back(pred);
         EXP_TYPED: expected_rsp.push_back(typed);
         default: ;
      endcase
      sent++;
      @(negedge clock);
   endtask

   // Wait for every response, then let the block finish any silent work
   task automatic settle();
      req_tvalid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_cap(input logic [CAP_W-1:0] v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      cap_model   = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Close the current path and drain the whole result
   task automatic end_and_drain();
      int n;
      send_req(CMD_END, 8'($urandom));
      n = result_len;
      repeat (n) send_req(CMD_DRAIN, 8'($urandom));
   endtask

   // Long plain paths: letters, with a slash after every seg_len letters
   task automatic send_span(input int n_bytes, input bit absolute, input int seg_len);
      int p;
      p = 0;
      if (absolute) send_req(CMD_BYTE, CHAR_SLASH);
      for (int k = absolute ? 1 : 0; k < n_bytes; k++) begin
         if (p == seg_len) begin
            send_req(CMD_BYTE, CHAR_SLASH);
            p = 0;
         end else begin
            send_req(CMD_BYTE, 8'(CHAR_A + $urandom_range(0, 25)));
            p++;
         end
      end
      end_and_drain();
      send_req(CMD_DRAIN, 8'($urandom));   // one tick past the end is ignored
   endtask

   // One path of random segments, with noise, then usually end marker and drain
   task automatic send_path(input int n_seg, input bit absolute, input int max_tok);
      logic [BYTE_W-1:0] seq[$];
      int                r, n_drain;
      if (absolute) seq.push_back(CHAR_SLASH);
      for (int k = 0; k < n_seg; k++) begin
         r = $urandom_range(0, 9);
         if (r == 1) begin
            seq.push_back(CHAR_DOT);
         end else if (r == 2 || r == 3) begin
            seq.push_back(CHAR_DOT);
            seq.push_back(CHAR_DOT);
         end else if (r > 3) begin
            repeat ($urandom_range(1, max_tok)) begin
               r = $urandom_range(0, 9);
               if (r < 2)
                  seq.push_back(CHAR_DOT);
               else if (r < 5)
                  seq.push_back(8'($urandom_range(1, 255)));
               else
                  seq.push_back(8'(CHAR_A + $urandom_range(0, 25)));
            end
         end
         // r == 0 leaves an empty segment
         if (k != n_seg - 1 || $urandom_range(0, 3) == 0) seq.push_back(CHAR_SLASH);
      end
      foreach (seq[i]) begin
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
               0: send_req(CMD_BYTE, CHAR_NUL);
               1: send_req(CMD_UNUSED, 8'($urandom));
               2: send_req(CMD_DRAIN, 8'($urandom));
               default: send_req(CMD_BYTE, 8'($urandom_range(1, 255)));
            endcase
         end
         send_req(CMD_BYTE, seq[i]);
      end
      r = $urandom_range(0, 19);
      // sometimes no end marker: the next path's bytes extend this one
      if (r == 0) return;
      send_req(CMD_END, 8'($urandom));
      if (r == 1) send_req(CMD_END, 8'($urandom));
      n_drain = result_len;
      r = $urandom_range(0, 9);
      if (r == 0 && n_drain > 0)
         n_drain = $urandom_range(0, n_drain - 1);   // next byte starts a new path
      else if (r == 1)
         n_drain += $urandom_range(1, 2);            // extra ticks are ignored
      repeat (n_drain) send_req(CMD_DRAIN, 8'($urandom));
   endtask

   task automatic random_paths(input int quota);
      int stop_at;
      stop_at = sent + quota;
      while (sent < stop_at) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 29) == 0)
            send_path($urandom_range(60, 70), 1'($urandom), 2);
         else
            send_path($urandom_range(0, 8), 1'($urandom), 6);
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------
   dir_row_type dir_rows [27] = '{
      '{CMD_DRAIN,  CHAR_NUL,   EXP_NONE,  '0},                              // drain while collecting
      '{CMD_END,    CHAR_NUL,   EXP_TYPED, '{1'b1, 1'b0, 10'd1, CHAR_NUL, 1'b0}},  // empty path
      '{CMD_DRAIN,  CHAR_NUL,   EXP_TYPED, '{1'b0, 1'b0, 10'd0, CHAR_DOT, 1'b1}},
      '{CMD_DRAIN,  CHAR_NUL,   EXP_NONE,  '0},                              // past the end
      '{CMD_END,    CHAR_NUL,   EXP_NONE,  '0},                              // end outside collect
      '{CMD_BYTE,   CHAR_SLASH, EXP_MODEL, '0},                              // "/.." fails
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},
      '{CMD_END,    CHAR_NUL,   EXP_TYPED, '{1'b1, 1'b1, 10'd0, CHAR_NUL, 1'b1}},
      '{CMD_DRAIN,  CHAR_NUL,   EXP_NONE,  '0},                              // nothing after failure
      '{CMD_BYTE,   8'hFF,      EXP_MODEL, '0},                              // relative path
      '{CMD_BYTE,   CHAR_NUL,   EXP_MODEL, '0},                              // zero byte skipped
      '{CMD_UNUSED, CHAR_SLASH, EXP_NONE,  '0},
      '{CMD_BYTE,   CHAR_SLASH, EXP_MODEL, '0},
      '{CMD_BYTE,   8'h01,      EXP_MODEL, '0},
      '{CMD_BYTE,   8'h80,      EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_SLASH, EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},                              // ".." pops a segment
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_SLASH, EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},                              // "." skipped
      '{CMD_END,    CHAR_NUL,   EXP_MODEL, '0},
      '{CMD_DRAIN,  CHAR_NUL,   EXP_MODEL, '0},
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},                              // relative top ".."
      '{CMD_BYTE,   CHAR_DOT,   EXP_MODEL, '0},
      '{CMD_END,    CHAR_NUL,   EXP_MODEL, '0},
      '{CMD_DRAIN,  CHAR_NUL,   EXP_MODEL, '0}
   };

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_BYTE;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      cap_model   = CAP_RESET;
      restart_path();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_req(dir_rows[i].cmd, dir_rows[i].b, dir_rows[i].src, dir_rows[i].rsp);

      // Segment limit at the reset capacity
      send_span(127, 1'b0, 1);            // segment limit reached
      send_span(129, 1'b0, 1);            // one segment too many

      // Capacity sweep, register written only with the block idle
      settle();
      write_cap('0);
      random_paths(30);
      settle();
      write_cap(11'd1);
      random_paths(30);
      settle();
      write_cap(11'd2);
      random_paths(40);
      settle();
      write_cap(11'($urandom_range(3, 30)));
      random_paths(200);
      settle();
      write_cap(11'(MAX_LEN));
      random_paths(60);
      settle();
      write_cap(11'($urandom_range(31, MAX_LEN)));
      random_paths(120);
      settle();
      write_cap(CAP_RESET);
      // receiver stops for a while; the block backs up into the request side
      long_hold = 1'b1;
      send_span(40, 1'b1, 4);
      random_paths(200);

      settle();
      repeat (16) @(negedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
